// File: design/variable_window_moving_average_top_defines.svh
// ----------------------------------------------------------------------------
// Variable-window moving average: assertion macros
// Shared property shapes for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH
`define VARIABLE_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VWMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define VWMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vwma_pkg.sv
// ----------------------------------------------------------------------------
// Variable-window moving average: package
// Widths and reset constants of the history, counter, window and divider.
// ----------------------------------------------------------------------------
package vwma_pkg;

  localparam int HistDepth = 16;
  localparam int SampleW   = 8;
  localparam int WinW      = 4;
  localparam int IdxW      = $clog2(HistDepth);
  localparam int CountW    = $clog2(HistDepth + 1);
  // sum of up to 15 samples of 8 bits
  localparam int SumW      = SampleW + WinW;
  localparam int QuoBitsW  = $clog2(SampleW);

  localparam logic [WinW-1:0] WinReset = WinW'(3);

endpackage

// File: design/variable_window_moving_average_top.sv
// ----------------------------------------------------------------------------
// Variable-window moving average
// Keeps a 16-entry sample history and averages the newest min(count, window)
// samples with a serial adder and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Channel   | Dir | Signals                          | Contents
// s_axis    | in  | tvalid, tready, tdata[7:0]       | sample
// m_axis    | out | tvalid, tready, tdata[7:0]       | average
// cfg       | in  | cfg_valid_i, cfg_ready_o, data   | window_len
//
// After a sample's transfer the sequencer adds one history entry per step for
// used = min(samples seen, window) entries, then runs eight divider steps, one
// per quotient bit, and loads the output register from the hold state. A new
// sample is taken only in the idle state, after the last result has left hold.
// Reset clears the sample count and sets the window to 3; no clearing pass.
// A result waits in the output register while the next sample is taken in;
// a finished result stalls in the hold state only if that register is full.
// ----------------------------------------------------------------------------
`include "variable_window_moving_average_top_defines.svh"

module variable_window_moving_average_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // cfg write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,     // [3:0] window_len
  // sample input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] sample
  // average output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] average
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                        state_q;
  logic [vwma_pkg::WinW-1:0]     win_len_q;
  logic [vwma_pkg::CountW-1:0]   count_q, count_d;
  logic [vwma_pkg::IdxW-1:0]     used_q, used_d;
  logic [vwma_pkg::IdxW-1:0]     idx_q;
  logic [vwma_pkg::SumW-1:0]     acc_q, acc_d;
  logic [vwma_pkg::WinW-1:0]     rem_q;
  logic [vwma_pkg::SampleW-1:0]  quo_q, quo_d;
  logic [vwma_pkg::WinW-1:0]     rem_d;
  logic [vwma_pkg::SampleW-1:0]  out_data_q;
  logic                          out_valid_q;
  logic [vwma_pkg::SampleW-1:0]  hist_q [vwma_pkg::HistDepth];
  logic [vwma_pkg::WinW-1:0]     win_eff;
  logic [vwma_pkg::WinW:0]       trial;
  logic                          quo_bit;
  logic                          in_xfer;
  logic                          sum_last;
  logic                          div_last;
  logic                          out_free;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Window of zero acts as one
  assign win_eff = (win_len_q == '0) ? vwma_pkg::WinW'(1) : win_len_q;

  // Saturating count and averaged length for the incoming sample
  always_comb begin
    count_d = count_q;
    if (count_q < vwma_pkg::CountW'(vwma_pkg::HistDepth)) begin
      count_d = count_q + 1'b1;
    end
    if (count_d < {1'b0, win_eff}) begin
      used_d = count_d[vwma_pkg::IdxW-1:0];
    end else begin
      used_d = win_eff;
    end
  end

  // Shared adder: one history entry per cycle
  assign acc_d    = acc_q + {{vwma_pkg::WinW{1'b0}}, hist_q[idx_q]};
  assign sum_last = (idx_q == used_q - 1'b1);

  // Restoring divider step: one quotient bit per cycle
  assign trial   = {rem_q, quo_q[vwma_pkg::SampleW-1]};
  assign quo_bit = (trial >= {1'b0, used_q});
  always_comb begin
    if (quo_bit) begin
      rem_d = vwma_pkg::WinW'(trial - {1'b0, used_q});
    end else begin
      rem_d = trial[vwma_pkg::WinW-1:0];
    end
    quo_d = {quo_q[vwma_pkg::SampleW-2:0], quo_bit};
  end
  assign div_last = (idx_q[vwma_pkg::QuoBitsW-1:0] ==
                     vwma_pkg::QuoBitsW'(vwma_pkg::SampleW - 1));

  // Sample history, newest at entry 0
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hist_q[0] <= s_axis_tdata;
      for (int k = 1; k < vwma_pkg::HistDepth; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Sequencer, window register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= vwma_pkg::WinReset;
      count_q     <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_len_q <= cfg_data_i;
      end
      // the hold state reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != ST_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            count_q <= count_d;
            used_q  <= used_d;
            idx_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          acc_q <= acc_d;
          if (sum_last) begin
            // quotient fits in 8 bits, so the top bits seed the remainder
            rem_q   <= acc_d[vwma_pkg::SumW-1:vwma_pkg::SampleW];
            quo_q   <= acc_d[vwma_pkg::SampleW-1:0];
            idx_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          idx_q <= idx_q + 1'b1;
          if (div_last) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= quo_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `VWMA_ASSERT_NEXT(a_xfer_starts_sum, in_xfer, state_q == ST_SUM, "transfer did not start sum")
  `VWMA_ASSERT_NOW(a_rem_below_divisor, state_q == ST_DIV, rem_q < used_q, "rem >= divisor")
  `VWMA_ASSERT_NOW(a_sum_idx_in_window, state_q == ST_SUM, idx_q < used_q, "index past window")
  `VWMA_ASSERT_NOW(a_out_from_hold, $rose(out_valid_q), $past(state_q) == ST_HOLD, "not from hold")

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Variable-window moving average: testbench
// Drives samples over the input stream with random gaps and output back-pressure,
// rewrites the window between phases while the block is idle, and checks every
// average against a table value or an in-bench model of history, count and window.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int  SampleW       = vwma_pkg::SampleW;
  localparam int  WinW          = vwma_pkg::WinW;
  localparam int  HistDepth     = vwma_pkg::HistDepth;
  localparam logic [WinW-1:0] WinReset = vwma_pkg::WinReset;

  localparam real ClkPeriod     = 4.0;
  localparam int  ResetCycles   = 10;
  localparam int  IdlePct       = 32;
  localparam int  WatchdogLimit = 2000;
  localparam int  HoldCycles    = 300;
  localparam int  TailCycles    = 40;
  localparam int  RandPhases    = 12;
  localparam int  PhaseItems    = 100;
  localparam int  CalmPhase     = 5;
  localparam int  HoldPhase     = 7;
  localparam int  MaxReports    = 10;
  localparam int  DirRows       = 22;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_e;

  // one line of the directed table; exp_avg only counts when has_exp is set
  typedef struct packed {
    row_kind_e          kind;
    logic [SampleW-1:0] value;
    logic               has_exp;
    logic [SampleW-1:0] exp_avg;
  } stim_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [WinW-1:0]    cfg_data_i    = '0;   // [3:0] window_len
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata  = '0;   // [7:0] sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;         // [7:0] average

  // model state
  logic [SampleW-1:0] hist_q [HistDepth];
  int unsigned        samples_seen;
  logic [WinW-1:0]    win_len;
  logic [SampleW-1:0] avg_expect_q [$];

  stim_row_t dir_tbl [DirRows];

  bit calm;          // no idling on either side
  bit hold_req;      // asks the receiver for one long hold-off
  bit hold_started;
  int hold_left;
  int mismatches;
  int stall_cycles;

  variable_window_moving_average_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // shift in a sample and average the newest min(seen, window) entries
  function automatic logic [SampleW-1:0] predict_average(input logic [SampleW-1:0] smp);
    int unsigned span;
    int unsigned used;
    int unsigned total;
    for (int k = HistDepth - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
    hist_q[0] = smp;
    if (samples_seen < HistDepth) samples_seen++;
    // a zero window passes the newest sample through
    span  = (win_len == 0) ? 1 : win_len;
    used  = (samples_seen < span) ? samples_seen : span;
    total = 0;
    for (int k = 0; k < used; k++) total += hist_q[k];
    return SampleW'(total / used);
  endfunction

  function automatic void note_mismatch(input string what, input logic [SampleW-1:0] want,
                                        input logic [SampleW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch (%s) at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endfunction

  // one sample transfer, with a random gap in front of it
  task automatic send_sample(input logic [SampleW-1:0] smp, input logic use_typed,
                             input logic [SampleW-1:0] typed_avg);
    int gap;
    logic [SampleW-1:0] pred;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_average(smp);
    avg_expect_q.push_back(use_typed ? typed_avg : pred);
  endtask

  // window write, only once every average is back
  task automatic write_window(input logic [WinW-1:0] w);
    s_axis_tvalid <= 1'b0;
    wait (avg_expect_q.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len = w;
  endtask

  // receiver: check each average transfer, then pick the next ready
  always @(posedge clk_i) begin : rx_side
    logic [SampleW-1:0] want_avg;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (avg_expect_q.size() == 0) begin
          note_mismatch("unexpected average", 'x, m_axis_tdata);
        end else begin
          want_avg = avg_expect_q.pop_front();
          if (m_axis_tdata !== want_avg) note_mismatch("average", want_avg, m_axis_tdata);
        end
      end
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WatchdogLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t          row;
    logic [WinW-1:0]    w;
    logic [SampleW-1:0] smp;
    int                 pick;

    for (int k = 0; k < HistDepth; k++) hist_q[k] = '0;
    samples_seen = 0;
    win_len      = WinReset;

    // directed part: reset window of 3, zero and above-nine windows, extremes
    dir_tbl = '{
      '{ROW_SAMPLE, 8'd255, 1'b1, 8'd255},  // single sample after reset
      '{ROW_SAMPLE, 8'd0,   1'b1, 8'd127},  // two samples, truncated
      '{ROW_SAMPLE, 8'd0,   1'b1, 8'd85},   // window just filled
      '{ROW_SAMPLE, 8'd0,   1'b1, 8'd0},    // oldest one dropped out
      '{ROW_WINDOW, 8'd0,   1'b0, 8'd0},    // zero window acts as one
      '{ROW_SAMPLE, 8'd200, 1'b1, 8'd200},
      '{ROW_SAMPLE, 8'd1,   1'b1, 8'd1},
      '{ROW_WINDOW, 8'd1,   1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd255, 1'b1, 8'd255},
      '{ROW_SAMPLE, 8'd0,   1'b1, 8'd0},
      '{ROW_WINDOW, 8'd15,  1'b0, 8'd0},    // widest window, count still short
      '{ROW_SAMPLE, 8'd255, 1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd255, 1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd128, 1'b0, 8'd0},
      '{ROW_WINDOW, 8'd9,   1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd255, 1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd255, 1'b0, 8'd0},
      '{ROW_WINDOW, 8'd10,  1'b0, 8'd0},    // above nine, used as written
      '{ROW_SAMPLE, 8'd0,   1'b0, 8'd0},
      '{ROW_WINDOW, 8'd2,   1'b0, 8'd0},    // history kept across the change
      '{ROW_SAMPLE, 8'd255, 1'b0, 8'd0},
      '{ROW_SAMPLE, 8'd255, 1'b1, 8'd255}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.kind == ROW_WINDOW) write_window(row.value[WinW-1:0]);
      else send_sample(row.value, row.has_exp, row.exp_avg);
    end

    // random phases, windows 9, 1, 0 and 15 first
    for (int ph = 0; ph < RandPhases; ph++) begin
      unique case (ph)
        0:       w = WinW'(9);
        1:       w = WinW'(1);
        2:       w = WinW'(0);
        3:       w = WinW'(15);
        default: w = WinW'($urandom_range(0, 15));
      endcase
      write_window(w);
      calm = (ph == CalmPhase);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == HoldPhase && i == 20) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 10)      smp = 8'd255;
        else if (pick < 20) smp = 8'd0;
        else if (pick < 30) smp = SampleW'($urandom_range(240, 255));
        else                smp = SampleW'($urandom_range(0, 255));
        send_sample(smp, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain, then watch the tail for stray results
    s_axis_tvalid <= 1'b0;
    wait (avg_expect_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && avg_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
